[hdl/scsa_pkg.sv]
// Shared types and constants of the size-class slab allocator.
package scsa_pkg;

  localparam int OPCODE_W        = 2;
  localparam int BYTES_W         = 8;
  localparam int CLASS_W         = 3;
  localparam int OFFSET_W        = 13;
  localparam int STATUS_W        = 3;
  localparam int MAX_REQ_CLASSES = 5;
  localparam int IN_TDATA_W      = 24;
  localparam int OUT_TDATA_W     = 24;

  typedef enum logic [OPCODE_W-1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_REINIT = 2'd2,
    OP_IGNORE = 2'd3
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 3'd0,
    ST_BAD_SIZE     = 3'd1,
    ST_OUT_OF_SPACE = 3'd2,
    ST_MISALIGNED   = 3'd3,
    ST_DOUBLE_FREE  = 3'd4,
    ST_NOT_MANAGED  = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_DIVIDE,
    S_MUL,
    S_FINISH
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic scan_step;
    logic div_step;
    logic mul;
    logic commit;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    opcode_t op;
    logic    class_bad;
    logic    scan_done;
    logic    div_last;
  } stat_t;

  typedef struct packed {
    status_t               status;
    logic [CLASS_W-1:0]    cls;
    logic [OFFSET_W-1:0]   offset;
    logic                  added;
  } result_t;

endpackage

[hdl/scsa_ctrl.sv]
// Sequencing state machine of the slab allocator.
module scsa_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  logic           out_free,
  input  scsa_pkg::stat_t stat,
  output scsa_pkg::cmd_t  cmd
);
  import scsa_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        case (stat.op)
          OP_ALLOC:  state_nxt = stat.class_bad ? S_FINISH : S_SCAN;
          OP_FREE:   state_nxt = stat.class_bad ? S_FINISH : S_DIVIDE;
          OP_REINIT: state_nxt = S_FINISH;
          default:   state_nxt = S_IDLE; // unused opcode: no result
        endcase
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_done) begin
          state_nxt = S_MUL;
        end
      end
      S_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_nxt = S_FINISH;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

[hdl/scsa_dp.sv]
// Datapath: class bitmaps, batch counts, batch scan, offset divider and multiplier.
module scsa_dp #(
  parameter int SLOTS_PER_BATCH = 8,
  parameter int MAX_BATCHES     = 8,
  parameter int ALIGN_BYTES     = 16,
  parameter int NUM_CLASSES     = 5
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  scsa_pkg::cmd_t                   cmd,
  output scsa_pkg::stat_t                  stat,
  input  scsa_pkg::opcode_t                in_op,
  input  logic [scsa_pkg::BYTES_W-1:0]     in_bytes,
  input  logic [scsa_pkg::CLASS_W-1:0]     in_class,
  input  logic [scsa_pkg::OFFSET_W-1:0]    in_offset,
  output scsa_pkg::result_t                result
);
  import scsa_pkg::*;

  localparam int TOTAL_SLOTS = MAX_BATCHES * SLOTS_PER_BATCH;
  localparam int SLOT_W      = $clog2(TOTAL_SLOTS);
  localparam int CNT_W       = $clog2(TOTAL_SLOTS + 1);
  localparam int BATCH_W     = $clog2(MAX_BATCHES + 1);
  localparam int BIDX_W      = (MAX_BATCHES > 1) ? $clog2(MAX_BATCHES) : 1;
  localparam int ENC_W       = $clog2(SLOTS_PER_BATCH);
  localparam int CIDX_W      = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int SIZE_W      = $clog2(NUM_CLASSES * ALIGN_BYTES + 1);
  localparam int LIMIT       = MAX_REQ_CLASSES * ALIGN_BYTES;
  localparam int CMP_W       = ($clog2(LIMIT + 1) > BYTES_W) ? $clog2(LIMIT + 1) : BYTES_W;
  localparam int CLS_CMP_W   = CLASS_W + 2;
  localparam int DIV_CNT_W   = $clog2(OFFSET_W);
  localparam int PROD_W      = SLOT_W + SIZE_W;

  // item registers
  opcode_t               op_r;
  logic [CLASS_W-1:0]    cls_r;
  logic [SIZE_W-1:0]     size_r;
  logic                  class_bad_r;
  logic [SIZE_W-1:0]     rem_r;
  logic [OFFSET_W-1:0]   q_r;
  logic [DIV_CNT_W-1:0]  div_cnt_r;
  logic [BATCH_W-1:0]    scan_b_r;
  logic [SLOT_W-1:0]     slot_r;
  logic                  added_r;
  logic                  full_r;
  logic [OFFSET_W-1:0]   prod_r;

  // allocator state
  logic [BATCH_W-1:0]     batches_r   [NUM_CLASSES];
  logic [BATCH_W-1:0]     batches_nxt [NUM_CLASSES];
  logic [TOTAL_SLOTS-1:0] maps_r      [NUM_CLASSES];
  logic [TOTAL_SLOTS-1:0] maps_nxt    [NUM_CLASSES];

  // load decode
  logic [CLASS_W-1:0] alloc_cls;
  logic               alloc_bad;
  logic               free_bad;
  logic [CLASS_W-1:0] load_cls;

  always_comb begin
    alloc_cls = '0;
    for (int k = 0; k < MAX_REQ_CLASSES; k++) begin
      if (CMP_W'(in_bytes) > CMP_W'(k * ALIGN_BYTES)) begin
        alloc_cls = alloc_cls + 1'b1;
      end
    end
  end

  assign alloc_bad = (in_bytes == '0) || (CMP_W'(in_bytes) > CMP_W'(LIMIT)) ||
                     (CLS_CMP_W'(alloc_cls) > CLS_CMP_W'(NUM_CLASSES));
  assign free_bad  = (in_class == '0) || (CLS_CMP_W'(in_class) > CLS_CMP_W'(NUM_CLASSES));
  assign load_cls  = (in_op == OP_ALLOC) ? alloc_cls : in_class;

  // current class
  logic [CIDX_W-1:0]      ci;
  logic [BATCH_W-1:0]     nb;
  logic [TOTAL_SLOTS-1:0] row;

  assign ci  = CIDX_W'(cls_r - 1'b1);
  assign nb  = class_bad_r ? '0 : batches_r[ci];
  assign row = class_bad_r ? '0 : maps_r[ci];

  // batch scan, one batch per cycle
  logic [BIDX_W-1:0]          bsel;
  logic                       at_end;
  logic [SLOTS_PER_BATCH-1:0] batch_row;
  logic [SLOTS_PER_BATCH-1:0] lowest;
  logic                       row_any;
  logic [ENC_W-1:0]           enc;

  assign bsel      = scan_b_r[BIDX_W-1:0];
  assign at_end    = (scan_b_r == nb);
  assign batch_row = row[int'(bsel) * SLOTS_PER_BATCH +: SLOTS_PER_BATCH];
  assign lowest    = batch_row & (~batch_row + 1'b1);
  assign row_any   = |batch_row;

  always_comb begin
    enc = '0;
    for (int i = 0; i < SLOTS_PER_BATCH; i++) begin
      if (lowest[i]) begin
        enc = enc | ENC_W'(i);
      end
    end
  end

  // restoring divider, one quotient bit per cycle
  logic [SIZE_W:0] trial;
  logic [SIZE_W:0] diff;
  logic            ge;

  assign trial = {rem_r, q_r[OFFSET_W-1]};
  assign diff  = trial - {1'b0, size_r};
  assign ge    = (trial >= {1'b0, size_r});

  logic [PROD_W-1:0] prod_full;
  assign prod_full = PROD_W'(slot_r) * PROD_W'(size_r);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r        <= in_op;
      cls_r       <= load_cls;
      size_r      <= SIZE_W'(int'(load_cls) * ALIGN_BYTES);
      class_bad_r <= (in_op == OP_ALLOC) ? alloc_bad : free_bad;
      rem_r       <= '0;
      q_r         <= in_offset;
      div_cnt_r   <= '0;
      scan_b_r    <= '0;
    end
    if (cmd.div_step) begin
      rem_r     <= ge ? diff[SIZE_W-1:0] : trial[SIZE_W-1:0];
      q_r       <= {q_r[OFFSET_W-2:0], ge};
      div_cnt_r <= div_cnt_r + 1'b1;
    end
    if (cmd.scan_step) begin
      if (at_end) begin
        slot_r  <= SLOT_W'(int'(nb) * SLOTS_PER_BATCH);
        added_r <= 1'b1;
        full_r  <= (nb >= BATCH_W'(MAX_BATCHES));
      end else if (row_any) begin
        slot_r  <= SLOT_W'(int'(bsel) * SLOTS_PER_BATCH + int'(enc));
        added_r <= 1'b0;
        full_r  <= 1'b0;
      end else begin
        scan_b_r <= scan_b_r + 1'b1;
      end
    end
    if (cmd.mul) begin
      prod_r <= OFFSET_W'(prod_full);
    end
  end

  // free checks on the divider result
  logic [CNT_W-1:0]  slots_avail;
  logic              in_range;
  logic [SLOT_W-1:0] fidx;
  logic              fbit;

  assign slots_avail = CNT_W'(int'(nb) * SLOTS_PER_BATCH);
  assign in_range    = (q_r < OFFSET_W'(slots_avail));
  assign fidx        = q_r[SLOT_W-1:0];
  assign fbit        = row[fidx];

  always_comb begin
    result = '0;
    case (op_r)
      OP_ALLOC: begin
        if (class_bad_r) begin
          result.status = ST_BAD_SIZE;
        end else if (full_r) begin
          result.status = ST_OUT_OF_SPACE;
        end else begin
          result.status = ST_OK;
          result.cls    = cls_r;
          result.offset = prod_r;
          result.added  = added_r;
        end
      end
      OP_FREE: begin
        if (class_bad_r || !in_range) begin
          result.status = ST_NOT_MANAGED;
        end else if (rem_r != '0) begin
          result.status = ST_MISALIGNED;
        end else if (fbit) begin
          result.status = ST_DOUBLE_FREE;
        end else begin
          result.status = ST_OK;
        end
      end
      default: result.status = ST_OK;
    endcase
  end

  // state update at commit
  logic [TOTAL_SLOTS-1:0] row_upd;

  always_comb begin
    batches_nxt = batches_r;
    maps_nxt    = maps_r;
    row_upd     = row;
    if (cmd.commit) begin
      case (op_r)
        OP_ALLOC: begin
          if (result.status == ST_OK) begin
            if (added_r) begin
              row_upd         = row_upd | (TOTAL_SLOTS'({SLOTS_PER_BATCH{1'b1}}) << slot_r);
              batches_nxt[ci] = nb + 1'b1;
            end
            row_upd      = row_upd & ~(TOTAL_SLOTS'(1'b1) << slot_r);
            maps_nxt[ci] = row_upd;
          end
        end
        OP_FREE: begin
          if (result.status == ST_OK) begin
            maps_nxt[ci] = row | (TOTAL_SLOTS'(1'b1) << fidx);
          end
        end
        OP_REINIT: begin
          for (int c = 0; c < NUM_CLASSES; c++) begin
            maps_nxt[c]    = '1;
            batches_nxt[c] = (c == 0) ? BATCH_W'(1) : '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        maps_r[c]    <= '1;
        batches_r[c] <= (c == 0) ? BATCH_W'(1) : '0;
      end
    end else begin
      maps_r    <= maps_nxt;
      batches_r <= batches_nxt;
    end
  end

  assign stat.op        = op_r;
  assign stat.class_bad = class_bad_r;
  assign stat.scan_done = at_end || row_any;
  assign stat.div_last  = (div_cnt_r == DIV_CNT_W'(OFFSET_W - 1));

endmodule

[hdl/size_class_slab_allocator.sv]
// Top level of the size-class slab allocator: ports, result register, controller and datapath.
//
// Usage: one request per input transfer (in_tuser = opcode, in_tdata = its arguments),
// one result transfer per allocate, free or reinitialise; opcode 3 is dropped silently.
// Items are handled one at a time by the controller; in_tready is high only while idle.
// Steps per item, from the input transfer to the result register being loaded:
//   allocate : decode, then a scan of the class bitmap one batch per cycle over
//              1 .. MAX_BATCHES + 1 batches, then the offset multiply
//   free     : decode, then the 13-step restoring divider for offset / slot size
//   reinit, bad size or bad class : decode only
// The next input transfer can follow in the cycle after the result register is loaded,
// so a new request is only taken once the previous one is through.
// Results sit in an output register; a new request is taken while the previous
// result still waits, but that request only completes once the register is free.
// When the result register is still full and out_tready is low, the controller waits
// in its final state holding the result; nothing is lost or repeated.
// Reset (rst_n low, synchronous) gives class 1 one batch, all other classes none,
// and marks every slot free; a reinitialise request does the same.
module size_class_slab_allocator #(
  parameter int SLOTS_PER_BATCH = 8,
  parameter int MAX_BATCHES     = 8,
  parameter int ALIGN_BYTES     = 16,
  parameter int NUM_CLASSES     = 5
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // [7:0] request_bytes, [10:8] free_class, [23:11] free_offset
  input  logic [scsa_pkg::IN_TDATA_W-1:0]      in_tdata,
  // [1:0] opcode
  input  logic [scsa_pkg::OPCODE_W-1:0]        in_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // [2:0] status, [5:3] granted_class, [18:6] granted_offset, [19] batch_added
  output logic [scsa_pkg::OUT_TDATA_W-1:0]     out_tdata
);
  import scsa_pkg::*;

  cmd_t    cmd;
  stat_t   stat;
  result_t result;

  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic                   out_free;

  // result register may be loaded when empty or being drained this cycle
  assign out_free = !out_valid_r || out_tready;

  scsa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_free  (out_free),
    .stat      (stat),
    .cmd       (cmd)
  );

  scsa_dp #(
    .SLOTS_PER_BATCH (SLOTS_PER_BATCH),
    .MAX_BATCHES     (MAX_BATCHES),
    .ALIGN_BYTES     (ALIGN_BYTES),
    .NUM_CLASSES     (NUM_CLASSES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_op     (opcode_t'(in_tuser)),
    .in_bytes  (in_tdata[7:0]),
    .in_class  (in_tdata[10:8]),
    .in_offset (in_tdata[23:11]),
    .result    (result)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload only, no reset
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data_r <= {4'b0000, result.added, result.offset, result.cls, result.status};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTH
  // a granted slot always carries an ok status
  a_grant_ok : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[5:3] != 3'd0) |-> (out_tdata[2:0] == ST_OK))
    else $error("granted class with non-ok status");

  // a new batch is only reported together with a granted slot
  a_added_grant : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[19]) |-> (out_tdata[5:3] != 3'd0))
    else $error("batch added without a grant");

  // the result register is never overwritten while a result still waits
  a_commit_free : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_valid_r || out_tready))
    else $error("result register overwritten");

  // an input transfer and a commit never fall in the same cycle
  a_one_item : assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |-> !cmd.commit)
    else $error("input taken while an item completes");
`endif

endmodule

[test/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the size-class slab allocator: directed table, then random traffic.
module tb_top;
  import scsa_pkg::*;

  localparam int SLOTS_PER_BATCH = 8;
  localparam int MAX_BATCHES     = 8;
  localparam int ALIGN_BYTES     = 16;
  localparam int NUM_CLASSES     = 5;
  localparam int TOTAL_SLOTS     = SLOTS_PER_BATCH * MAX_BATCHES;

  localparam int RANDOM_ITEMS    = 2000;
  localparam int BURST_EVERY     = 400;   // one class is driven to full this often
  localparam int WATCHDOG_CYCLES = 3000;  // cycles with no transfer on either side
  localparam int TAIL_CYCLES     = 40;    // room after the last answer for any stray result to show up
  localparam int HOLD_AFTER      = 300;   // results seen before the long hold-off
  localparam int HOLD_CYCLES     = 400;

  // a slot handed out and not yet given back
  typedef struct packed {
    logic [CLASS_W-1:0]  cls;
    logic [OFFSET_W-1:0] offset;
  } slot_ref_t;

  // one row of the directed table; want is only used when typed is set
  typedef struct packed {
    opcode_t             op;
    logic [BYTES_W-1:0]  bytes;
    logic [CLASS_W-1:0]  cls;
    logic [OFFSET_W-1:0] offset;
    logic                typed;
    result_t             want;
  } stim_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // [7:0] request_bytes, [10:8] free_class, [23:11] free_offset
  logic [OPCODE_W-1:0]    in_tuser;   // [1:0] opcode
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // [2:0] status, [5:3] class, [18:6] offset, [19] batch_added

  // allocator state as this bench sees it
  int              batch_cnt [1:NUM_CLASSES];
  logic [TOTAL_SLOTS-1:0] slot_free [1:NUM_CLASSES];   // 1 = free
  slot_ref_t       granted_slots[$];
  result_t         answers_due[$];

  int mismatches   = 0;
  int results_seen = 0;
  int n_items      = 0;
  int quiet        = 0;

  size_class_slab_allocator #(
    .SLOTS_PER_BATCH (SLOTS_PER_BATCH),
    .MAX_BATCHES     (MAX_BATCHES),
    .ALIGN_BYTES     (ALIGN_BYTES),
    .NUM_CLASSES     (NUM_CLASSES)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic note_mismatch(input string what, input int got, input int want);
    mismatches++;
    $display("mismatch at result %0d, %s: got %0d, expected %0d", results_seen, what, got, want);
  endtask

  // back to the state after reset: class 1 holds one batch, every slot free
  task automatic clear_slabs();
    int c;
    for (c = 1; c <= NUM_CLASSES; c++) begin
      batch_cnt[c] = 0;
      slot_free[c] = '1;
    end
    batch_cnt[1] = 1;
    granted_slots.delete();
  endtask

  // Works out the answer to one accepted request and moves the state on.
  task automatic apply_request(input opcode_t op, input logic [BYTES_W-1:0] bytes,
                               input logic [CLASS_W-1:0] cls_in,
                               input logic [OFFSET_W-1:0] off_in,
                               output bit has_answer, output result_t ans);
    int c, nb, slot, sz, total, i;
    bit found;
    slot_ref_t granted;
    ans = '0;
    ans.status = ST_OK;
    has_answer = 1'b1;
    case (op)
      OP_ALLOC: begin
        c = (int'(bytes) + ALIGN_BYTES - 1) / ALIGN_BYTES;
        if (bytes == 0 || int'(bytes) > MAX_REQ_CLASSES * ALIGN_BYTES || c > NUM_CLASSES) begin
          ans.status = ST_BAD_SIZE;
        end else begin
          nb = batch_cnt[c];
          found = 1'b0;
          slot = 0;
          // lowest free slot among the batches already open
          for (i = 0; i < nb * SLOTS_PER_BATCH; i++) begin
            if (!found && slot_free[c][i]) begin
              slot = i;
              found = 1'b1;
            end
          end
          if (!found && nb >= MAX_BATCHES) begin
            ans.status = ST_OUT_OF_SPACE;
          end else begin
            if (!found) begin
              for (i = 0; i < SLOTS_PER_BATCH; i++) slot_free[c][nb * SLOTS_PER_BATCH + i] = 1'b1;
              slot = nb * SLOTS_PER_BATCH;
              batch_cnt[c] = nb + 1;
              ans.added = 1'b1;
            end
            slot_free[c][slot] = 1'b0;
            ans.cls = CLASS_W'(c);
            ans.offset = OFFSET_W'(slot * c * ALIGN_BYTES);
            granted.cls = CLASS_W'(c);
            granted.offset = ans.offset;
            granted_slots.push_back(granted);
          end
        end
      end
      OP_FREE: begin
        if (cls_in < 1 || cls_in > NUM_CLASSES) begin
          ans.status = ST_NOT_MANAGED;
        end else begin
          c = int'(cls_in);
          sz = c * ALIGN_BYTES;
          total = batch_cnt[c] * SLOTS_PER_BATCH * sz;
          if (int'(off_in) >= total) begin
            ans.status = ST_NOT_MANAGED;
          end else if (int'(off_in) % sz != 0) begin
            ans.status = ST_MISALIGNED;
          end else begin
            slot = int'(off_in) / sz;
            if (slot_free[c][slot]) begin
              ans.status = ST_DOUBLE_FREE;
            end else begin
              slot_free[c][slot] = 1'b1;
              for (i = 0; i < granted_slots.size(); i++) begin
                if (granted_slots[i].cls == cls_in && granted_slots[i].offset == off_in) begin
                  granted_slots.delete(i);
                  break;
                end
              end
            end
          end
        end
      end
      OP_REINIT: clear_slabs();
      default: has_answer = 1'b0;   // unused opcode: dropped, no result
    endcase
  endtask

  // Idle gap before the next request; some stretches run back to back.
  function automatic int sender_gap();
    int r;
    if ((n_items / 100) % 5 == 4) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offers one request, waits for its transfer, then records what should come back.
  task automatic issue(input opcode_t op, input int bytes, input int cls, input int off,
                       input logic typed, input result_t want);
    int gap;
    bit has_answer;
    result_t ans;
    gap = sender_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {off[OFFSET_W-1:0], cls[CLASS_W-1:0], bytes[BYTES_W-1:0]};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    apply_request(op, bytes[BYTES_W-1:0], cls[CLASS_W-1:0], off[OFFSET_W-1:0], has_answer, ans);
    if (has_answer) begin
      answers_due.push_back(typed ? want : ans);
      n_items++;
    end
  endtask

  function automatic stim_row_t row(input opcode_t op, input int bytes, input int cls,
                                    input int off, input logic typed, input status_t st,
                                    input int g_cls, input int g_off, input logic added);
    stim_row_t s;
    s.op          = op;
    s.bytes       = BYTES_W'(bytes);
    s.cls         = CLASS_W'(cls);
    s.offset      = OFFSET_W'(off);
    s.typed       = typed;
    s.want.status = st;
    s.want.cls    = CLASS_W'(g_cls);
    s.want.offset = OFFSET_W'(g_off);
    s.want.added  = added;
    return s;
  endfunction

  // Stimulus: the directed table first, then random traffic with a full-class burst now and then.
  initial begin : stimulus
    stim_row_t directed[$];
    slot_ref_t pick;
    int i, r, c, sz, nb, off, bytes, next_burst;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = OP_ALLOC;
    clear_slabs();

    // extremes of the size field, then every way a free can go wrong
    directed.push_back(row(OP_ALLOC,    1, 0,    0, 1, ST_OK,          1, 0, 0));
    directed.push_back(row(OP_ALLOC,    0, 0,    0, 1, ST_BAD_SIZE,    0, 0, 0));
    directed.push_back(row(OP_ALLOC,   80, 0,    0, 1, ST_OK,          5, 0, 1)); // empty class
    directed.push_back(row(OP_ALLOC,   81, 0,    0, 1, ST_BAD_SIZE,    0, 0, 0));
    directed.push_back(row(OP_ALLOC,  255, 0,    0, 1, ST_BAD_SIZE,    0, 0, 0));
    directed.push_back(row(OP_FREE,     0, 0,    0, 1, ST_NOT_MANAGED, 0, 0, 0));
    directed.push_back(row(OP_FREE,     0, 6,    0, 1, ST_NOT_MANAGED, 0, 0, 0));
    directed.push_back(row(OP_FREE,     0, 7, 8191, 1, ST_NOT_MANAGED, 0, 0, 0));
    directed.push_back(row(OP_FREE,     0, 3,    0, 1, ST_NOT_MANAGED, 0, 0, 0)); // no batches
    directed.push_back(row(OP_FREE,     0, 1,    8, 1, ST_MISALIGNED,  0, 0, 0));
    directed.push_back(row(OP_FREE,     0, 1,   32, 1, ST_DOUBLE_FREE, 0, 0, 0));
    directed.push_back(row(OP_FREE,     0, 1,  128, 1, ST_NOT_MANAGED, 0, 0, 0)); // just past end
    directed.push_back(row(OP_FREE,     0, 1, 8191, 1, ST_NOT_MANAGED, 0, 0, 0));
    directed.push_back(row(OP_FREE,     0, 1,    0, 1, ST_OK,          0, 0, 0));
    directed.push_back(row(OP_FREE,     0, 1,    0, 1, ST_DOUBLE_FREE, 0, 0, 0));
    directed.push_back(row(OP_FREE,     0, 5,    0, 1, ST_OK,          0, 0, 0));
    directed.push_back(row(OP_IGNORE, 255, 7, 8191, 0, ST_OK,          0, 0, 0)); // dropped
    directed.push_back(row(OP_ALLOC,   16, 0,    0, 0, ST_OK,          0, 0, 0));
    directed.push_back(row(OP_ALLOC,   17, 0,    0, 0, ST_OK,          0, 0, 0));
    directed.push_back(row(OP_ALLOC,   48, 0,    0, 0, ST_OK,          0, 0, 0));
    directed.push_back(row(OP_ALLOC,   64, 0,    0, 0, ST_OK,          0, 0, 0));
    directed.push_back(row(OP_ALLOC,   79, 0,    0, 0, ST_OK,          0, 0, 0));
    directed.push_back(row(OP_REINIT,   0, 0,    0, 1, ST_OK,          0, 0, 0));
    directed.push_back(row(OP_ALLOC,   80, 0,    0, 1, ST_OK,          5, 0, 1)); // fresh again

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < directed.size(); i++) begin
      issue(directed[i].op, directed[i].bytes, directed[i].cls, directed[i].offset,
            directed[i].typed, directed[i].want);
    end

    n_items = 0;
    next_burst = BURST_EVERY / 2;
    while (n_items < RANDOM_ITEMS) begin
      if (n_items >= next_burst) begin
        // fill one class to its last batch and beyond, then free randomly chosen granted slots
        next_burst += BURST_EVERY;
        c = $urandom_range(1, NUM_CLASSES);
        repeat (TOTAL_SLOTS + 6) begin
          issue(OP_ALLOC, c * ALIGN_BYTES - $urandom_range(0, ALIGN_BYTES - 1),
                $urandom_range(0, 7), $urandom_range(0, 8191), 1'b0, '0);
        end
        repeat (24) begin
          if (granted_slots.size() != 0) begin
            pick = granted_slots[$urandom_range(0, granted_slots.size() - 1)];
            issue(OP_FREE, $urandom_range(0, 255), pick.cls, pick.offset, 1'b0, '0);
          end
        end
      end else begin
        r = $urandom_range(0, 999);
        if (r < 4) begin
          issue(OP_REINIT, $urandom_range(0, 255), $urandom_range(0, 7),
                $urandom_range(0, 8191), 1'b0, '0);
        end else if (r < 20) begin
          issue(OP_IGNORE, $urandom_range(0, 255), $urandom_range(0, 7),
                $urandom_range(0, 8191), 1'b0, '0);
        end else if (r < 40) begin
          // raw noise on every field
          issue(opcode_t'($urandom_range(0, 1)), $urandom_range(0, 255), $urandom_range(0, 7),
                $urandom_range(0, 8191), 1'b0, '0);
        end else if (r < 540 || granted_slots.size() == 0) begin
          r = $urandom_range(0, 19);
          bytes = (r == 0) ? 0 : (r == 1) ? $urandom_range(81, 255) : $urandom_range(1, 80);
          issue(OP_ALLOC, bytes, $urandom_range(0, 7), $urandom_range(0, 8191), 1'b0, '0);
        end else if (r < 900) begin
          pick = granted_slots[$urandom_range(0, granted_slots.size() - 1)];
          issue(OP_FREE, $urandom_range(0, 255), pick.cls, pick.offset, 1'b0, '0);
        end else begin
          // frees that are mostly wrong: stale slots, misaligned, off the end
          c  = $urandom_range(0, 7);
          sz = c * ALIGN_BYTES;
          nb = (c >= 1 && c <= NUM_CLASSES) ? batch_cnt[c] : 0;
          off = $urandom_range(0, 8191);
          if (nb != 0) begin
            case ($urandom_range(0, 2))
              1: off = $urandom_range(0, nb * SLOTS_PER_BATCH - 1) * sz;
              2: off = $urandom_range(0, nb * SLOTS_PER_BATCH - 1) * sz + $urandom_range(1, sz - 1);
              default: ;
            endcase
          end
          issue(OP_FREE, $urandom_range(0, 255), c, off, 1'b0, '0);
        end
      end
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("** size_class_slab_allocator: PASSED **");
    end else begin
      $display("** size_class_slab_allocator: FAILED **");
    end
    $finish;
  end

  // Receiver: random back-pressure, stretches with none, and one long hold-off to fill the block and stall its input.
  initial begin : receiver
    int stall_left, r;
    bit held;
    out_tready = 1'b0;
    stall_left = 0;
    held = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (!held && results_seen >= HOLD_AFTER) begin
        held = 1'b1;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else if ((results_seen / 150) % 5 == 2) begin
        out_tready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 65) begin
          out_tready <= 1'b1;
        end else begin
          out_tready <= 1'b0;
          stall_left = (r < 94) ? $urandom_range(0, 2) : $urandom_range(8, 40);
        end
      end
    end
  end

  // Each result transfer against the oldest outstanding answer, field by field.
  always @(posedge clk) begin : result_check
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (answers_due.size() == 0) begin
        note_mismatch("result with nothing outstanding", out_tdata, 0);
      end else begin
        want = answers_due.pop_front();
        if (out_tdata[2:0] != want.status)
          note_mismatch("status", out_tdata[2:0], want.status);
        if (out_tdata[5:3] != want.cls)
          note_mismatch("granted_class", out_tdata[5:3], want.cls);
        if (out_tdata[18:6] != want.offset)
          note_mismatch("granted_offset", out_tdata[18:6], want.offset);
        if (out_tdata[19] != want.added)
          note_mismatch("batch_added", out_tdata[19], want.added);
        if (out_tdata[OUT_TDATA_W-1:20] != '0)
          note_mismatch("padding", out_tdata[OUT_TDATA_W-1:20], 0);
      end
      results_seen++;
    end
  end

  // Watchdog: too long without a transfer on either side means the block is stuck.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= WATCHDOG_CYCLES) begin
        $display("** size_class_slab_allocator: FAILED **");
        $finish;
      end
    end
  end

endmodule

[sim.f]
hdl/scsa_pkg.sv
hdl/scsa_ctrl.sv
hdl/scsa_dp.sv
hdl/size_class_slab_allocator.sv
test/tb_top.sv
